[src/bde_pkg.sv]
// shared types, codes and helper functions for the bit and divide execute unit
`default_nettype none

package bde_pkg;

  localparam int unsigned DIV_STEPS = 32;

  localparam logic [4:0]  POS_MASK = 5'b11111;
  localparam logic [2:0]  CC_TRUE  = 3'b010;
  localparam logic [2:0]  CC_FALSE = 3'b000;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

  typedef enum logic [3:0] {
    OP_DIVU     = 4'd0,
    OP_DIVI     = 4'd1,
    OP_REMU     = 4'd2,
    OP_REMI     = 4'd3,
    OP_CHKBIT   = 4'd4,
    OP_ALTERBIT = 4'd5,
    OP_EXTRACT  = 4'd6,
    OP_SCANBIT  = 4'd7,
    OP_SPANBIT  = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_DIV_ZERO = 2'd1,
    FAULT_OVERFLOW = 2'd2
  } fault_t;

  // how the back end finishes an item
  typedef enum logic [1:0] {
    K_PLAIN = 2'd0,
    K_CC    = 2'd1,
    K_ALTER = 2'd2,
    K_DIV   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_FIN  = 2'd2
  } back_state_t;

  // classified item; opnd_a and opnd_b carry magnitudes for divides,
  // the value and the one-hot bit mask for alterbit
  typedef struct packed {
    kind_t       kind;
    logic [31:0] pre_result;
    logic        cc_flag;
    fault_t      fault;
    logic        rem_op;
    logic        negate;
    logic [31:0] opnd_a;
    logic [31:0] opnd_b;
  } bde_item_t;

  function automatic logic [31:0] magnitude(input logic [31:0] v);
    magnitude = v[31] ? (32'd0 - v) : v;
  endfunction

  // index of the highest set bit by halving, all ones when none
  function automatic logic [31:0] find_top_set(input logic [31:0] v);
    logic [4:0]  idx;
    logic [15:0] v16;
    logic [7:0]  v8;
    logic [3:0]  v4;
    logic [1:0]  v2;
    idx    = '0;
    idx[4] = |v[31:16];
    v16    = idx[4] ? v[31:16] : v[15:0];
    idx[3] = |v16[15:8];
    v8     = idx[3] ? v16[15:8] : v16[7:0];
    idx[2] = |v8[7:4];
    v4     = idx[2] ? v8[7:4] : v8[3:0];
    idx[1] = |v4[3:2];
    v2     = idx[1] ? v4[3:2] : v4[1:0];
    idx[0] = v2[1];
    find_top_set = (|v) ? {27'd0, idx} : ALL_ONES;
  endfunction

endpackage

`default_nettype wire

[src/bde_front.sv]
// front end: takes an item, classifies it and hands it to the queue
`default_nettype none

module bde_front import bde_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  opcode,
  input  wire logic [31:0] operand_a,
  input  wire logic [31:0] operand_b,
  input  wire logic [5:0]  field_length,
  output logic             push,
  input  wire logic        full,
  output bde_item_t        push_item
);

  logic      held;
  bde_item_t item;
  bde_item_t item_next;
  logic      take;

  logic [31:0] bit_mask;
  logic [31:0] len_mask;
  logic [31:0] top_a;
  logic [31:0] top_na;
  logic        b_zero;
  logic        sign_ovf;

  assign in_stall  = held && full;
  assign take      = in_valid && !in_stall;
  assign push      = held;
  assign push_item = item;

  assign bit_mask = 32'd1 << (operand_b[4:0] & POS_MASK);
  assign len_mask = field_length[5] ? ALL_ONES : ((32'd1 << field_length[4:0]) - 32'd1);
  assign top_a    = find_top_set(operand_a);
  assign top_na   = find_top_set(~operand_a);
  assign b_zero   = (operand_b == 32'd0);
  assign sign_ovf = (operand_a == SIGN_BIT) && (operand_b == ALL_ONES);

  always_comb begin
    item_next            = '0;
    item_next.kind       = K_PLAIN;
    item_next.fault      = FAULT_NONE;
    item_next.pre_result = '0;
    unique case (opcode)
      OP_DIVU, OP_REMU: begin
        if (b_zero) begin
          item_next.fault = FAULT_DIV_ZERO;
        end else begin
          item_next.kind   = K_DIV;
          item_next.rem_op = (opcode == OP_REMU);
          item_next.opnd_a = operand_a;
          item_next.opnd_b = operand_b;
        end
      end
      OP_DIVI, OP_REMI: begin
        if (b_zero) begin
          item_next.fault = FAULT_DIV_ZERO;
        end else if (sign_ovf) begin
          // most negative by minus one: quotient overflows, remainder is zero
          item_next.fault = (opcode == OP_DIVI) ? FAULT_OVERFLOW : FAULT_NONE;
        end else begin
          item_next.kind   = K_DIV;
          item_next.rem_op = (opcode == OP_REMI);
          item_next.negate = (opcode == OP_DIVI) ? (operand_a[31] ^ operand_b[31])
                                                 : operand_a[31];
          item_next.opnd_a = magnitude(operand_a);
          item_next.opnd_b = magnitude(operand_b);
        end
      end
      OP_CHKBIT: begin
        item_next.kind    = K_CC;
        item_next.cc_flag = |(operand_a & bit_mask);
      end
      OP_ALTERBIT: begin
        item_next.kind   = K_ALTER;
        item_next.opnd_a = operand_a;
        item_next.opnd_b = bit_mask;
      end
      OP_EXTRACT: begin
        item_next.pre_result = (operand_a >> (operand_b[4:0] & POS_MASK)) & len_mask;
      end
      OP_SCANBIT: begin
        item_next.kind       = K_CC;
        item_next.pre_result = top_a;
        item_next.cc_flag    = |operand_a;
      end
      OP_SPANBIT: begin
        item_next.kind       = K_CC;
        item_next.pre_result = top_na;
        item_next.cc_flag    = |(~operand_a);
      end
      default: begin
        item_next.kind = K_PLAIN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (!full) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

[src/bde_queue.sv]
// short queue of classified items between front and back end
`default_nettype none

module bde_queue import bde_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire bde_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           nonempty,
  output bde_item_t      pop_item
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  bde_item_t       entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full     = (count == CntW'(DEPTH));
  assign nonempty = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

[src/bde_back.sv]
// back end: iterative divider, condition code and result register
`default_nettype none

module bde_back import bde_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      nonempty,
  input  wire bde_item_t pop_item,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output logic [31:0]    result,
  output logic [2:0]     condition_code,
  output logic [1:0]     fault
);

  localparam int unsigned CountW = $clog2(DIV_STEPS);

  back_state_t state;
  back_state_t state_next;

  logic [2:0]        cc;
  logic [31:0]       rem;
  logic [31:0]       quot;
  logic [31:0]       divisor;
  logic [CountW-1:0] count;
  logic              negate;
  logic              rem_op;

  logic        out_free;
  logic        load_direct;
  logic        load_fin;
  logic        start_div;
  logic        last_step;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic [31:0] fin_value;
  logic [31:0] direct_result;
  logic [2:0]  direct_cc;

  assign out_free  = !out_valid || !out_stall;
  assign last_step = (count == CountW'(DIV_STEPS - 1));

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted   = {rem, quot[31]};
  assign diff      = shifted - {1'b0, divisor};
  assign fin_value = rem_op ? rem : quot;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (nonempty && out_free && pop_item.kind == K_DIV) state_next = BK_DIV;
      BK_DIV:  if (last_step) state_next = BK_FIN;
      BK_FIN:  if (out_free) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop         = (state == BK_IDLE) && nonempty && out_free;
    start_div   = pop && (pop_item.kind == K_DIV);
    load_direct = pop && (pop_item.kind != K_DIV);
    load_fin    = (state == BK_FIN) && out_free;
  end

  always_comb begin
    direct_result = pop_item.pre_result;
    direct_cc     = cc;
    unique case (pop_item.kind)
      K_PLAIN: direct_result = pop_item.pre_result;
      K_CC: begin
        direct_result = pop_item.pre_result;
        direct_cc     = pop_item.cc_flag ? CC_TRUE : CC_FALSE;
      end
      K_ALTER: begin
        direct_result = cc[1] ? (pop_item.opnd_a | pop_item.opnd_b)
                              : (pop_item.opnd_a & ~pop_item.opnd_b);
      end
      K_DIV: direct_result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      cc        <= CC_FALSE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_direct) begin
        cc <= direct_cc;
      end
      if (load_direct || load_fin) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_div) begin
      rem     <= '0;
      quot    <= pop_item.opnd_a;
      divisor <= pop_item.opnd_b;
      negate  <= pop_item.negate;
      rem_op  <= pop_item.rem_op;
      count   <= '0;
    end else if (state == BK_DIV) begin
      rem   <= diff[32] ? shifted[31:0] : diff[31:0];
      quot  <= {quot[30:0], !diff[32]};
      count <= count + CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      result         <= direct_result;
      condition_code <= direct_cc;
      fault          <= pop_item.fault;
    end else if (load_fin) begin
      result         <= negate ? (32'd0 - fin_value) : fin_value;
      condition_code <= cc;
      fault          <= FAULT_NONE;
    end
  end

endmodule

`default_nettype wire

[src/bit_and_divide_execute_unit.sv]
// top level of the bit and divide execute unit
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   in      | in_valid, in_stall | opcode, operand_a, operand_b, field_length
//   out     | out_valid,out_stall| result, condition_code, fault
//
// divides go through the queue pop, 32 restoring steps in the shared divider and
// a sign fix-up; bit operations finish in the pop cycle, one a cycle while the
// back end is idle and out_stall is low. a taken item reaches the back end via the
// front register, then the queue. rst is synchronous, empties the pipe and clears the
// internal condition code to 000. out_stall holds the result register; the front
// keeps taking items until the queue and front register are full.
`default_nettype none

module bit_and_divide_execute_unit import bde_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  opcode,
  input  wire logic [31:0] operand_a,
  input  wire logic [31:0] operand_b,
  input  wire logic [5:0]  field_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      result,
  output logic [2:0]       condition_code,
  output logic [1:0]       fault
);

  logic      push;
  logic      full;
  logic      pop;
  logic      nonempty;
  bde_item_t push_item;
  bde_item_t pop_item;

  bde_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .field_length (field_length),
    .push         (push),
    .full         (full),
    .push_item    (push_item)
  );

  bde_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .nonempty  (nonempty),
    .pop_item  (pop_item)
  );

  bde_back u_back (
    .clk            (clk),
    .rst            (rst),
    .nonempty       (nonempty),
    .pop_item       (pop_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result         (result),
    .condition_code (condition_code),
    .fault          (fault)
  );

endmodule

`default_nettype wire
